// File: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted event priority queue.
// No dependencies; used by spq_cell and sorted_event_priority_queue.
package spq_pkg;

    localparam int KIND_W = 8;
    localparam int TIME_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] etime;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_ctrl;

endpackage

// File: rtl/core/spq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on spq_pkg for the entry and control types.
module spq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spq_pkg::t_ctrl  i_ctrl,
    input  spq_pkg::t_entry i_new,
    input  spq_pkg::t_entry i_left_entry,
    input  logic            i_left_valid,
    input  logic            i_left_push,
    input  spq_pkg::t_entry i_right_entry,
    input  logic            i_right_valid,
    output spq_pkg::t_entry o_entry,
    output logic            o_valid,
    output logic            o_push
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            r_valid;
    logic            n_valid;

    // push: the new item belongs at or ahead of this slot
    assign o_push  = !r_valid || (r_entry.etime >= i_new.etime);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            if (o_push) begin
                n_entry = i_left_push ? i_left_entry : i_new;
                n_valid = r_valid | i_left_valid;
            end
        end else if (i_ctrl.rem) begin
            n_entry = i_right_entry;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// File: rtl/core/sorted_event_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted event priority queue: a chain of spq_cell slots.
// Depends on spq_pkg and spq_cell.
//
//  channel | handshake         | payload
//  --------+-------------------+--------------------------------------------
//  command | start / busy      | i_opcode, i_event_kind, i_event_time
//  result  | o_done (strobe)   | o_status, o_out_kind, o_out_time, o_occupancy
//
// One item per cycle: every slot compares its time with the new item in
// parallel and shifts in the same cycle, so the chain update sets the rate.
// The result strobes in the cycle after the item is taken; busy stays low.
// Synchronous reset empties the chain at once by clearing the valid bits.
// The receiver cannot stall; each result is shown for one cycle only.
module sorted_event_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [spq_pkg::KIND_W-1:0] i_event_kind,
    input  logic [spq_pkg::TIME_W-1:0] i_event_time,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [spq_pkg::KIND_W-1:0] o_out_kind,
    output logic [spq_pkg::TIME_W-1:0] o_out_time,
    output logic [spq_pkg::OCC_W-1:0]  o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    spq_pkg::t_entry            w_entry [CAPACITY];
    logic [CAPACITY-1:0]        w_valid;
    logic [CAPACITY-1:0]        w_push;
    spq_pkg::t_entry            w_new;
    spq_pkg::t_ctrl             w_ctrl;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_done;
    spq_pkg::t_status           r_status;
    spq_pkg::t_status           n_status;
    logic [spq_pkg::KIND_W-1:0] r_kind;
    logic [spq_pkg::KIND_W-1:0] n_kind;
    logic [spq_pkg::TIME_W-1:0] r_time;
    logic [spq_pkg::TIME_W-1:0] n_time;
    logic [CNT_W+spq_pkg::OCC_W-1:0] w_occ_ext;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = w_valid[CAPACITY-1];
    assign w_empty  = !w_valid[0];
    assign w_new    = '{kind: i_event_kind, etime: i_event_time};

    assign w_ctrl.ins = w_accept && (i_opcode == spq_pkg::OP_INSERT) && !w_full;
    assign w_ctrl.rem = w_accept && (i_opcode == spq_pkg::OP_REMOVE) && !w_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry w_le;
        logic            w_lv;
        logic            w_lp;
        spq_pkg::t_entry w_re;
        logic            w_rv;

        if (g == 0) begin : g_head
            assign w_le = w_new;
            assign w_lv = 1'b1;
            assign w_lp = 1'b0;
        end else begin : g_mid
            assign w_le = w_entry[g-1];
            assign w_lv = w_valid[g-1];
            assign w_lp = w_push[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_re = w_new;
            assign w_rv = 1'b0;
        end else begin : g_body
            assign w_re = w_entry[g+1];
            assign w_rv = w_valid[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_new         (w_new),
            .i_left_entry  (w_le),
            .i_left_valid  (w_lv),
            .i_left_push   (w_lp),
            .i_right_entry (w_re),
            .i_right_valid (w_rv),
            .o_entry       (w_entry[g]),
            .o_valid       (w_valid[g]),
            .o_push        (w_push[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_INSERTED;
        n_kind   = '0;
        n_time   = '0;
        if (i_opcode == spq_pkg::OP_INSERT) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_status = spq_pkg::ST_REMOVED;
                n_kind   = w_entry[0].kind;
                n_time   = w_entry[0].etime;
                n_count  = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_kind   <= n_kind;
            r_time   <= n_time;
        end
    end

    assign w_occ_ext   = {{spq_pkg::OCC_W{1'b0}}, r_count};
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_kind  = r_kind;
    assign o_out_time  = r_time;
    assign o_occupancy = w_occ_ext[spq_pkg::OCC_W-1:0];

endmodule
